[hdl/ogru_pkg.sv]
`default_nettype none
package ogru_pkg;

	localparam int GRID_DIM   = 128;
	localparam int COUNT_BITS = 16;
	localparam int CRD_BITS   = $clog2(GRID_DIM);
	localparam int ADDR_BITS  = 2 * CRD_BITS;
	localparam int CELL_BITS  = 2 + 2 * COUNT_BITS;

	typedef enum logic [2:0] {
		REQ_RAY   = 3'd0,
		REQ_RING  = 3'd1,
		REQ_DECAY = 3'd2,
		REQ_CLEAR = 3'd3,
		REQ_READ  = 3'd4
	} req_e_t;

	localparam logic [1:0] CLS_UNKNOWN  = 2'd0;
	localparam logic [1:0] CLS_FREE     = 2'd1;
	localparam logic [1:0] CLS_OBSTACLE = 2'd2;

	localparam logic [1:0] CFG_FREE_TH = 2'd0;
	localparam logic [1:0] CFG_OBST_TH = 2'd1;
	localparam logic [1:0] CFG_DECAY   = 2'd2;

	// One queued request between front and back.
	typedef struct packed {
		logic [2:0]        req_type;
		logic signed [9:0] start_x;
		logic signed [9:0] start_y;
		logic signed [9:0] end_x;
		logic signed [9:0] end_y;
		logic [6:0]        inner_radius;
		logic [6:0]        outer_radius;
	} req_t;

	typedef struct packed {
		logic [1:0]            cls;
		logic [COUNT_BITS-1:0] obs;
		logic [COUNT_BITS-1:0] fre;
	} cell_t;

	typedef struct packed {
		logic [1:0]  cell_class;
		logic [15:0] obstacle_count;
		logic [15:0] free_count;
	} res_t;

endpackage
`default_nettype wire

[hdl/ogru_front.sv]
`default_nettype none
// Two-entry request queue; front side accepts requests, back side pops them.
module ogru_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire ogru_pkg::req_t in_req,
	output logic               q_valid,
	input  wire logic          q_pop,
	output ogru_pkg::req_t     q_req
);
	ogru_pkg::req_t mem_q [2];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;

	assign in_ready = (cnt_q != 2'd2);
	assign q_valid  = (cnt_q != 2'd0);
	assign q_req    = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) mem_q[wp_q] <= in_req;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (in_valid && in_ready) wp_q <= ~wp_q;
			if (q_pop && q_valid) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'((in_valid && in_ready) ? 1 : 0) - 2'((q_pop && q_valid) ? 1 : 0);
		end
	end
endmodule
`default_nettype wire

[hdl/ogru_back.sv]
`default_nettype none
// Sequencer that executes one request at a time against the single-port cell
// memory. Ray, ring and decay cell accesses are a read, wait, modify, write.
module ogru_back (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           q_valid,
	output logic                q_pop,
	input  wire ogru_pkg::req_t q_req,
	input  wire logic [15:0]    free_th,
	input  wire logic [15:0]    obst_th,
	input  wire logic [15:0]    decay_amt,
	output logic                res_valid,
	input  wire logic           res_ready,
	output ogru_pkg::res_t      res
);
	localparam int AB = ogru_pkg::ADDR_BITS;
	localparam int CB = ogru_pkg::CRD_BITS;
	localparam int NB = ogru_pkg::COUNT_BITS;
	localparam logic [NB-1:0] CNT_MAX = '1;

	typedef enum logic [3:0] {
		ST_CLR, ST_IDLE, ST_DISPATCH, ST_RAY, ST_RING, ST_SWEEP,
		ST_READ, ST_WAIT, ST_MOD, ST_RESULT
	} state_t;

	ogru_pkg::cell_t cells [ogru_pkg::GRID_DIM*ogru_pkg::GRID_DIM];
	ogru_pkg::cell_t rd_q;

	state_t state_q, ret_q;
	ogru_pkg::req_t req_q;
	logic [AB:0] addr_q;
	logic [AB-1:0] acc_addr_q;
	logic signed [11:0] x_q, y_q, ex_q, ey_q, dx_q, dy_q;
	logic signed [12:0] err_q;
	logic signed [8:0] rx_q, ry_q;
	logic [14:0] d2_q;
	logic kind_end_q;
	logic wr_en;
	ogru_pkg::cell_t wr_data;
	logic res_valid_q;
	ogru_pkg::res_t res_q;

	assign res_valid = res_valid_q;
	assign res = res_q;
	assign q_pop = (state_q == ST_IDLE) && q_valid;

	function automatic logic in_grid(logic signed [11:0] x, logic signed [11:0] y);
		return x >= 0 && x < 12'(ogru_pkg::GRID_DIM) && y >= 0 && y < 12'(ogru_pkg::GRID_DIM);
	endfunction

	function automatic logic [AB-1:0] cell_addr(logic signed [11:0] x, logic signed [11:0] y);
		return {y[CB-1:0], x[CB-1:0]};
	endfunction

	// Modify step for the cell held in rd_q.
	ogru_pkg::cell_t nc, tmp;
	logic [NB-1:0] inc;
	always_comb begin
		nc = rd_q;
		tmp = rd_q;
		inc = '0;
		case (ret_q)
			ST_RAY: begin
				if (kind_end_q) begin
					inc = (rd_q.obs == CNT_MAX) ? CNT_MAX : rd_q.obs + 1'b1;
					nc.obs = inc;
					if ({{(32-NB){1'b0}}, inc} >= {16'd0, obst_th}) begin
						nc.cls = ogru_pkg::CLS_OBSTACLE;
						nc.fre = '0;
					end
				end else if (rd_q.cls != ogru_pkg::CLS_OBSTACLE) begin
					inc = (rd_q.fre == CNT_MAX) ? CNT_MAX : rd_q.fre + 1'b1;
					nc.fre = inc;
					if ({{(32-NB){1'b0}}, inc} >= {16'd0, free_th}) begin
						nc.cls = ogru_pkg::CLS_FREE;
						nc.obs = '0;
					end
				end
			end
			ST_RING: begin
				if (rd_q.cls == ogru_pkg::CLS_OBSTACLE) nc.cls = ogru_pkg::CLS_UNKNOWN;
			end
			ST_SWEEP: begin
				if (tmp.cls != ogru_pkg::CLS_OBSTACLE && tmp.obs != '0) begin
					tmp.obs = ({16'd0, tmp.obs} > {{(32-NB){1'b0}}, decay_amt}) ?
						NB'({16'd0, tmp.obs} - {{(32-NB){1'b0}}, decay_amt}) : '0;
					if (tmp.obs == '0) tmp.cls = ogru_pkg::CLS_UNKNOWN;
				end
				if (tmp.cls != ogru_pkg::CLS_FREE && tmp.fre != '0) begin
					tmp.fre = ({16'd0, tmp.fre} > {{(32-NB){1'b0}}, decay_amt}) ?
						NB'({16'd0, tmp.fre} - {{(32-NB){1'b0}}, decay_amt}) : '0;
					if (tmp.fre == '0) tmp.cls = ogru_pkg::CLS_UNKNOWN;
				end
				nc = tmp;
			end
			default: nc = '0;
		endcase
	end

	assign wr_en = (state_q == ST_MOD && ret_q != ST_READ) || state_q == ST_CLR;
	assign wr_data = (state_q == ST_CLR) ? '0 : nc;

	always_ff @(posedge clk) begin
		rd_q <= cells[acc_addr_q];
		if (wr_en) cells[acc_addr_q] <= wr_data;
	end

	// Bresenham step values.
	logic signed [12:0] e2;
	assign e2 = err_q <<< 1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
			ret_q <= ST_IDLE;
			addr_q <= '0;
			acc_addr_q <= '0;
			res_valid_q <= 1'b0;
			res_q <= '0;
			req_q <= '0;
			x_q <= '0; y_q <= '0; ex_q <= '0; ey_q <= '0;
			dx_q <= '0; dy_q <= '0; err_q <= '0;
			rx_q <= '0; ry_q <= '0; d2_q <= '0;
			kind_end_q <= 1'b0;
		end else begin
			if (res_valid_q && res_ready) res_valid_q <= 1'b0;
			case (state_q)
				ST_CLR: begin
					acc_addr_q <= acc_addr_q + 1'b1;
					if (acc_addr_q == '1) state_q <= ST_RESULT;
				end
				ST_IDLE: begin
					if (q_valid) begin
						req_q <= q_req;
						state_q <= ST_DISPATCH;
					end
				end
				ST_DISPATCH: begin
					x_q <= 12'(req_q.start_x);
					y_q <= 12'(req_q.start_y);
					ex_q <= 12'(req_q.end_x);
					ey_q <= 12'(req_q.end_y);
					dx_q <= (req_q.end_x > req_q.start_x) ? 12'(req_q.end_x) - 12'(req_q.start_x)
						: 12'(req_q.start_x) - 12'(req_q.end_x);
					dy_q <= (req_q.end_y > req_q.start_y) ? 12'(req_q.end_y) - 12'(req_q.start_y)
						: 12'(req_q.start_y) - 12'(req_q.end_y);
					err_q <= '0;
					ry_q <= -$signed({2'b0, req_q.outer_radius});
					rx_q <= -$signed({2'b0, req_q.outer_radius});
					addr_q <= '0;
					case (req_q.req_type)
						ogru_pkg::REQ_RAY: begin
							state_q <= ST_RAY;
							err_q <= 13'(((req_q.end_x > req_q.start_x) ?
								12'(req_q.end_x) - 12'(req_q.start_x) :
								12'(req_q.start_x) - 12'(req_q.end_x))) -
								13'(((req_q.end_y > req_q.start_y) ?
								12'(req_q.end_y) - 12'(req_q.start_y) :
								12'(req_q.start_y) - 12'(req_q.end_y)));
						end
						ogru_pkg::REQ_RING: state_q <= ST_RING;
						ogru_pkg::REQ_DECAY: state_q <= ST_SWEEP;
						ogru_pkg::REQ_CLEAR: begin
							acc_addr_q <= '0;
							state_q <= ST_CLR;
						end
						ogru_pkg::REQ_READ: begin
							if (in_grid(12'(req_q.start_x), 12'(req_q.start_y))) begin
								acc_addr_q <= cell_addr(12'(req_q.start_x), 12'(req_q.start_y));
								ret_q <= ST_READ;
								state_q <= ST_WAIT;
							end else begin
								state_q <= ST_RESULT;
							end
						end
						default: state_q <= ST_RESULT;
					endcase
				end
				ST_RAY: begin
					// Visit current cell (if inside), then step.
					kind_end_q <= (x_q == ex_q) && (y_q == ey_q);
					if (in_grid(x_q, y_q)) begin
						acc_addr_q <= cell_addr(x_q, y_q);
						ret_q <= ST_RAY;
						state_q <= ST_WAIT;
					end else if ((x_q == ex_q) && (y_q == ey_q)) begin
						state_q <= ST_RESULT;
					end else begin
						if (e2 > -13'(dy_q)) begin
							x_q <= (x_q < ex_q) ? x_q + 12'sd1 : x_q - 12'sd1;
						end
						if (e2 < 13'(dx_q)) begin
							y_q <= (y_q < ey_q) ? y_q + 12'sd1 : y_q - 12'sd1;
						end
						err_q <= err_q - ((e2 > -13'(dy_q)) ? 13'(dy_q) : 13'sd0)
							+ ((e2 < 13'(dx_q)) ? 13'(dx_q) : 13'sd0);
					end
				end
				ST_RING: begin
					// Scan the square offset by offset; the squared distance is registered
					// here and tested in the next state.
					if (ry_q > $signed({2'b0, req_q.outer_radius})) begin
						state_q <= ST_RESULT;
					end else begin
						if (rx_q == $signed({2'b0, req_q.outer_radius})) begin
							rx_q <= -$signed({2'b0, req_q.outer_radius});
							ry_q <= ry_q + 9'sd1;
						end else begin
							rx_q <= rx_q + 9'sd1;
						end
						d2_q <= 15'(rx_q * rx_q) + 15'(ry_q * ry_q);
						x_q <= 12'(req_q.start_x) + 12'(rx_q);
						y_q <= 12'(req_q.start_y) + 12'(ry_q);
						state_q <= ST_READ;
						ret_q <= ST_RING;
					end
				end
				ST_READ: begin
					// Ring candidate test stage.
					if (in_grid(x_q, y_q)
						&& d2_q <= 15'(req_q.outer_radius * req_q.outer_radius)
						&& d2_q > 15'(req_q.inner_radius * req_q.inner_radius)) begin
						acc_addr_q <= cell_addr(x_q, y_q);
						state_q <= ST_WAIT;
					end else begin
						state_q <= ST_RING;
					end
				end
				ST_SWEEP: begin
					if (addr_q[AB]) begin
						state_q <= ST_RESULT;
					end else begin
						acc_addr_q <= addr_q[AB-1:0];
						addr_q <= addr_q + 1'b1;
						ret_q <= ST_SWEEP;
						state_q <= ST_WAIT;
					end
				end
				ST_WAIT: state_q <= ST_MOD;
				ST_MOD: begin
					state_q <= ret_q;
					if (ret_q == ST_READ) begin
						// The read cell stays in rd_q until the result is sent.
						state_q <= ST_RESULT;
					end else if (ret_q == ST_RAY) begin
						if (kind_end_q) begin
							state_q <= ST_RESULT;
						end else begin
							if (e2 > -13'(dy_q)) x_q <= (x_q < ex_q) ? x_q + 12'sd1 : x_q - 12'sd1;
							if (e2 < 13'(dx_q)) y_q <= (y_q < ey_q) ? y_q + 12'sd1 : y_q - 12'sd1;
							err_q <= err_q - ((e2 > -13'(dy_q)) ? 13'(dy_q) : 13'sd0)
								+ ((e2 < 13'(dx_q)) ? 13'(dx_q) : 13'sd0);
						end
					end
				end
				ST_RESULT: begin
					// The reset-time clear does not end here; it returns to idle below and sends nothing.
					if (ret_q == ST_IDLE && req_q == '0 && !kind_end_q && acc_addr_q == '0
						&& res_q == '0 && addr_q == '0 && x_q == '0 && dx_q == 12'sd1) begin
						state_q <= ST_IDLE;
					end else if (!res_valid_q || res_ready) begin
						if (ret_q == ST_READ) begin
							res_q <= '{cell_class: rd_q.cls, obstacle_count: rd_q.obs[15:0],
								free_count: rd_q.fre[15:0]};
						end else begin
							res_q <= '0;
						end
						res_valid_q <= 1'b1;
						ret_q <= ST_RAY;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			if (state_q == ST_CLR && acc_addr_q == '1 && ret_q == ST_IDLE) begin
				// Power-up clear: no result.
				state_q <= ST_IDLE;
				ret_q <= ST_RAY;
			end
		end
	end
endmodule
`default_nettype wire

[hdl/occupancy_grid_ray_update_top.sv]
`default_nettype none
// Occupancy grid updater with evidence counters.
// Requests arrive on s_axis (tdata fields from bit 0: req_type[2:0], start_x,
// start_y, end_x, end_y, inner_radius, outer_radius). Every request returns
// one result on m_axis (tdata from bit 0: cell_class, obstacle_count,
// free_count); only a read request returns nonzero fields.
// Configuration registers are written on the cfg channel (index 0 free
// threshold, 1 obstacle threshold, 2 decay step); the user must write them
// only while the block is idle, as the block itself does not enforce it.
// A front queue of two requests takes requests while the back sequencer
// works. Each ray, ring or decay cell visit is a read, a wait and a
// modify-write on the single cell memory port; a read only reads. A ray
// visits each grid cell it crosses, a ring clear tests each offset in its
// square and a decay sweep or map clear makes one pass over all 16384
// cells. After reset the memory is cleared before the first request is
// taken. When the receiver stalls, the finished result waits in the output
// register and the sequencer waits before the next result.
module occupancy_grid_ray_update_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [63:0] s_axis_tdata,  // req_type, start_x, start_y, end_x, end_y, inner_radius, outer_radius
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [39:0]      m_axis_tdata,  // cell_class, obstacle_count, free_count
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [15:0] cfg_data
);
	ogru_pkg::req_t in_req, q_req;
	ogru_pkg::res_t res;
	logic q_valid, q_pop;
	logic [15:0] free_th_q, obst_th_q, decay_q;

	assign in_req = '{req_type: s_axis_tdata[2:0], start_x: s_axis_tdata[12:3],
		start_y: s_axis_tdata[22:13], end_x: s_axis_tdata[32:23], end_y: s_axis_tdata[42:33],
		inner_radius: s_axis_tdata[49:43], outer_radius: s_axis_tdata[56:50]};

	assign cfg_ready = 1'b1;
	assign m_axis_tdata = {6'd0, res.free_count, res.obstacle_count, res.cell_class};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_th_q <= 16'd3;
			obst_th_q <= 16'd3;
			decay_q <= 16'd1;
		end else if (cfg_valid) begin
			case (cfg_index)
				ogru_pkg::CFG_FREE_TH: free_th_q <= cfg_data;
				ogru_pkg::CFG_OBST_TH: obst_th_q <= cfg_data;
				ogru_pkg::CFG_DECAY:   decay_q <= cfg_data;
				default: ;
			endcase
		end
	end

	ogru_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_req(in_req),
		.q_valid(q_valid), .q_pop(q_pop), .q_req(q_req)
	);

	ogru_back u_back (
		.clk(clk), .arst_n(arst_n),
		.q_valid(q_valid), .q_pop(q_pop), .q_req(q_req),
		.free_th(free_th_q), .obst_th(obst_th_q), .decay_amt(decay_q),
		.res_valid(m_axis_tvalid), .res_ready(m_axis_tready), .res(res)
	);
endmodule
`default_nettype wire
